### hw/rtl/fixed_width_radix_digits_assert.svh
// Assertion macros for the fixed-width radix digit formatter.
// Used by fwrd_cell and fixed_width_radix_digits; no other dependencies.
`ifndef FIXED_WIDTH_RADIX_DIGITS_ASSERT_SVH
`define FIXED_WIDTH_RADIX_DIGITS_ASSERT_SVH
`ifndef SYNTH
`define FWRD_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("fwrd assertion failed");
`define FWRD_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("fwrd assertion failed");
`else
`define FWRD_ASSERT_IMP(label, clk, rst_n, a, c)
`define FWRD_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/fwrd_pkg.sv
// Shared constants and types for the fixed-width radix digit formatter.
// No dependencies.
`default_nettype none
package fwrd_pkg;
  localparam int MAX_DIGITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int DIG_W      = 4;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int POS_W      = 5;
  localparam int RADIX_W    = 5;
  localparam int ADDR_W     = 7;
  localparam int CHAR_W     = 7;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'd97;

  // Per-cycle shift control handed to every cell of the digit row.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) c = CH_ZERO + {3'b000, d};
    else           c = CH_LOWER_A + {3'b000, d} - 7'd10;
    return c;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/fixed_width_radix_digits.sv
// Top level of the fixed-width radix digit formatter.
// Depends on fwrd_pkg, fwrd_divider, fwrd_cell and the assertion header.
//
//  channel | ports                                           | direction
//  in      | in_valid/in_ready, value, digit_count, radix,   | request in
//          | start_address                                   |
//  out     | out_valid/out_ready, character, digit_position, | request out
//          | string_address, last_digit                      |
//
// Flow: each digit costs one divider pass, so a request of n digits takes n
// divider passes to convert, then n output digits at one per clock when
// out_ready stays high.
// Reset: rst_n synchronous active low clears control; the digit row needs no
// clearing since every cell read is written first in the same request.
// Stalls: out_ready low holds the current digit; in_ready stays low until the
// last digit of a request leaves.
`default_nettype none
`include "fixed_width_radix_digits_assert.svh"
module fixed_width_radix_digits (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_value,
  input  wire logic [5:0]  in_digit_count,
  input  wire logic [4:0]  in_radix,
  input  wire logic [6:0]  in_start_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_character,
  output logic [4:0]       out_digit_position,
  output logic [6:0]       out_string_address,
  output logic             out_last_digit
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam int ND = fwrd_pkg::MAX_DIGITS;

  logic [1:0]                       state_r;
  logic [fwrd_pkg::CNT_W-1:0]       n_r;
  logic [fwrd_pkg::CNT_W-1:0]       cnt_r;
  logic [fwrd_pkg::POS_W-1:0]       pos_r;
  logic [fwrd_pkg::RADIX_W-1:0]     radix_r;
  logic [fwrd_pkg::ADDR_W-1:0]      addr_r;
  logic [fwrd_pkg::VALUE_BITS-1:0]  quot_r;
  logic [fwrd_pkg::VALUE_BITS-1:0]  working_quotient_r;
  logic                             div_start;
  logic                             div_done;
  logic [fwrd_pkg::VALUE_BITS-1:0]  div_q;
  logic [fwrd_pkg::DIG_W-1:0]       div_rem;
  logic [fwrd_pkg::CNT_W-1:0]       n_sat;
  logic [fwrd_pkg::RADIX_W-1:0]     r_sat;
  fwrd_pkg::cell_ctl_t              ctl;
  logic [fwrd_pkg::DIG_W-1:0]       cell_out [ND];
  logic                             out_fire;

  // Saturate the count and clamp the radix as requested items allow any bits.
  always_comb begin
    if (in_digit_count > 6'(ND)) n_sat = fwrd_pkg::CNT_W'(ND);
    else                         n_sat = fwrd_pkg::CNT_W'(in_digit_count);
    if (in_radix < 5'd2)       r_sat = 5'd2;
    else if (in_radix > 5'd16) r_sat = 5'd16;
    else                       r_sat = in_radix;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign out_fire  = out_valid && out_ready;
  assign div_start = (state_r == ST_DIV);

  // Row of cells: each remainder enters at cell 0 and pushes the older digits
  // one cell up, so after n remainders the most significant digit sits at
  // cell 0 and the least significant at cell n-1.
  // During emission the row shifts down by one per accepted digit, so cell 0
  // always holds the digit on offer; only cell 0 is ever read.
  always_comb begin
    ctl.load  = 1'b0;
    ctl.shift = div_done || out_fire;
  end

  for (genvar g = 0; g < ND; g++) begin : g_cell
    logic [fwrd_pkg::DIG_W-1:0] sin;
    if (g == 0) begin : g_first
      assign sin = div_done ? div_rem : cell_out[1];
    end else if (g == ND - 1) begin : g_last
      assign sin = div_done ? cell_out[g-1] : '0;
    end else begin : g_mid
      assign sin = div_done ? cell_out[g-1] : cell_out[g+1];
    end
    fwrd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .load_digit (div_rem),
      .shift_in   (sin),
      .digit      (cell_out[g])
    );
  end

  fwrd_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (quot_r),
    .divisor   (radix_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Emit from the head of the row: it holds the most significant digit not
  // yet accepted.
  logic [fwrd_pkg::DIG_W-1:0] cur_digit;
  assign cur_digit = cell_out[0];

  assign out_character      = fwrd_pkg::ascii_of(cur_digit);
  assign out_digit_position = pos_r;
  assign out_string_address = addr_r;
  assign out_last_digit     = (cnt_r == fwrd_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      cnt_r              <= '0;
      pos_r              <= '0;
      working_quotient_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            quot_r  <= in_value;
            n_r     <= n_sat;
            cnt_r   <= n_sat;
            radix_r <= r_sat;
            addr_r  <= in_start_address;
            pos_r   <= '0;
            if (n_sat == '0) working_quotient_r <= in_value;
            else             state_r <= ST_DIV;
          end
        end
        ST_DIV: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            quot_r <= div_q;
            if (cnt_r == fwrd_pkg::CNT_W'(1)) begin
              working_quotient_r <= div_q;
              cnt_r   <= n_r;
              state_r <= ST_EMIT;
            end else begin
              cnt_r   <= cnt_r - 1'b1;
              state_r <= ST_DIV;
            end
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            pos_r <= pos_r + 1'b1;
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == fwrd_pkg::CNT_W'(1)) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `FWRD_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !in_ready)
  `FWRD_ASSERT_IMP(a_emit_cnt, clk, rst_n, out_valid, cnt_r != '0)
  `FWRD_ASSERT_IMP(a_done_waits, clk, rst_n, div_done, state_r == ST_WAIT)
  `FWRD_ASSERT_NXT(a_last_ends, clk, rst_n, out_fire && out_last_digit, state_r == ST_IDLE)
endmodule
`default_nettype wire

### hw/rtl/fwrd_divider.sv
// Bit-serial restoring divider: quotient and remainder of value by radix.
// Depends on fwrd_pkg.
`default_nettype none
module fwrd_divider (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [fwrd_pkg::VALUE_BITS-1:0] dividend,
  input  wire logic [fwrd_pkg::RADIX_W-1:0]    divisor,
  output logic                                 done,
  output logic [fwrd_pkg::VALUE_BITS-1:0]      quotient,
  output logic [fwrd_pkg::DIG_W-1:0]           remainder
);
  logic [fwrd_pkg::VALUE_BITS-1:0] q_r;
  logic [fwrd_pkg::RADIX_W-1:0]    rem_r;
  logic [fwrd_pkg::BIT_CNT_W-1:0]  cnt_r;
  logic                            busy_r;
  logic [fwrd_pkg::RADIX_W:0]      trial;

  assign trial = {rem_r, q_r[fwrd_pkg::VALUE_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= fwrd_pkg::BIT_CNT_W'(fwrd_pkg::VALUE_BITS);
        q_r    <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        // One quotient bit per cycle.
        if (trial >= {1'b0, divisor}) begin
          rem_r <= fwrd_pkg::RADIX_W'(trial - {1'b0, divisor});
          q_r   <= {q_r[fwrd_pkg::VALUE_BITS-2:0], 1'b1};
        end else begin
          rem_r <= trial[fwrd_pkg::RADIX_W-1:0];
          q_r   <= {q_r[fwrd_pkg::VALUE_BITS-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == fwrd_pkg::BIT_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r[fwrd_pkg::DIG_W-1:0];
endmodule
`default_nettype wire

### hw/rtl/fwrd_cell.sv
// One cell of the digit row: holds one digit and passes it to its neighbor.
// Depends on fwrd_pkg and the assertion header.
`default_nettype none
`include "fixed_width_radix_digits_assert.svh"
module fwrd_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fwrd_pkg::cell_ctl_t        ctl,
  input  wire logic [fwrd_pkg::DIG_W-1:0] load_digit,
  input  wire logic [fwrd_pkg::DIG_W-1:0] shift_in,
  output logic [fwrd_pkg::DIG_W-1:0]      digit
);
  logic [fwrd_pkg::DIG_W-1:0] digit_r;

  // Load takes the newest digit and wins over shift; shift takes shift_in from a neighbor.
  always_ff @(posedge clk) begin
    if (ctl.load)       digit_r <= load_digit;
    else if (ctl.shift) digit_r <= shift_in;
  end

  assign digit = digit_r;

  `FWRD_ASSERT_IMP(a_ctl_excl, clk, rst_n, ctl.load, !ctl.shift)
  `FWRD_ASSERT_NXT(a_load_takes, clk, rst_n, ctl.load, digit_r == $past(load_digit))
  `FWRD_ASSERT_NXT(a_idle_hold, clk, rst_n, !ctl.load && !ctl.shift, $stable(digit_r))
endmodule
`default_nettype wire
